// ----- hdl/odd_pkg.sv -----
// Shared types and constants for the octant direction and distance block.
package odd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int DIST_BITS      = 17;
    localparam int HEAD_BITS      = 3;

    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    localparam logic [HEAD_BITS-1:0] HEAD_N  = 3'd0;
    localparam logic [HEAD_BITS-1:0] HEAD_NE = 3'd1;
    localparam logic [HEAD_BITS-1:0] HEAD_E  = 3'd2;
    localparam logic [HEAD_BITS-1:0] HEAD_SE = 3'd3;
    localparam logic [HEAD_BITS-1:0] HEAD_S  = 3'd4;
    localparam logic [HEAD_BITS-1:0] HEAD_SW = 3'd5;
    localparam logic [HEAD_BITS-1:0] HEAD_W  = 3'd6;
    localparam logic [HEAD_BITS-1:0] HEAD_NW = 3'd7;

    typedef struct packed {
        logic                 valid;
        logic [HEAD_BITS-1:0] heading;
        logic                 same;
        logic                 sat;
    } side_t;

endpackage

// ----- hdl/octant_direction_and_distance.sv -----
// Top level: compass octant and rounded Euclidean distance between two grid positions.
//
// Usage:
//   A transfer is taken on each rising edge with start high and busy low. busy is
//   always low, so a new position pair may be offered in every cycle.
//   Each transfer gives one result: heading, same_position and distance, held on the
//   ports for exactly one cycle with done high. The receiver cannot stall; results
//   leave in the order the pairs arrived.
//   There are RB = min(COORD_BITS + 1, 17) + 1 root cells. Throughput: one pair per cycle.
//   The latency is set by the chain of square root cells, one root bit per cell,
//   after four front stages (difference, magnitudes and octant, squares, sum).
//   Reset empties the pipeline: no done strobe follows for pairs taken before it.
module octant_direction_and_distance
    import odd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [COORD_BITS-1:0] from_x,
    input  logic signed [COORD_BITS-1:0] from_y,
    input  logic signed [COORD_BITS-1:0] to_x,
    input  logic signed [COORD_BITS-1:0] to_y,
    output logic                         done,
    output logic [HEAD_BITS-1:0]         heading,
    output logic                         same_position,
    output logic [DIST_BITS-1:0]         distance
);

    localparam int MB = ((COORD_BITS + 1) < DIST_BITS) ? (COORD_BITS + 1) : DIST_BITS;
    localparam int SB = 2 * MB + 1;
    localparam int RB = MB + 1;
    localparam int FW = ((RB + 1) > DIST_BITS) ? (RB + 1) : DIST_BITS;

    side_t         side_f;
    logic [SB-1:0] sum_f;

    side_t           side_c [0:RB];
    logic [2*RB-1:0] s_c    [0:RB-1];
    logic [RB-1:0]   q_c    [0:RB];
    logic [RB+1:0]   r_c    [0:RB];

    logic                 done_reg;
    logic [HEAD_BITS-1:0] heading_reg;
    logic                 same_reg;
    logic [DIST_BITS-1:0] dist_reg, dist_next;
    logic [FW-1:0]        rounded;

    assign busy = 1'b0;

    odd_front #(
        .COORD_BITS (COORD_BITS),
        .MB         (MB),
        .SB         (SB)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (start && !busy),
        .from_x (from_x),
        .from_y (from_y),
        .to_x   (to_x),
        .to_y   (to_y),
        .side   (side_f),
        .sum    (sum_f)
    );

    assign side_c[0] = side_f;
    assign s_c[0]    = {1'b0, sum_f};
    assign q_c[0]    = '0;
    assign r_c[0]    = '0;

    for (genvar i = 0; i < RB; i++)
    begin : g_cell
        if (i < RB - 1)
        begin : g_mid
            odd_sqrt_cell #(.RB(RB)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .side_in  (side_c[i]),
                .s_in     (s_c[i]),
                .q_in     (q_c[i]),
                .r_in     (r_c[i]),
                .side_out (side_c[i+1]),
                .s_out    (s_c[i+1]),
                .q_out    (q_c[i+1]),
                .r_out    (r_c[i+1])
            );
        end
        else
        begin : g_last
            odd_sqrt_cell #(.RB(RB)) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .side_in  (side_c[i]),
                .s_in     (s_c[i]),
                .q_in     (q_c[i]),
                .r_in     (r_c[i]),
                .side_out (side_c[i+1]),
                .s_out    (),
                .q_out    (q_c[i+1]),
                .r_out    (r_c[i+1])
            );
        end
    end

    // round half up: the remainder exceeds the root exactly when S > r*r + r
    always_comb
    begin
        rounded = FW'(q_c[RB]) + FW'(r_c[RB] > (RB+2)'(q_c[RB]));
        if (side_c[RB].sat || (rounded > FW'(DIST_MAX)))
        begin
            dist_next = DIST_MAX;
        end
        else
        begin
            dist_next = rounded[DIST_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= side_c[RB].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        heading_reg <= side_c[RB].heading;
        same_reg    <= side_c[RB].same;
        dist_reg    <= dist_next;
    end

    assign done          = done_reg;
    assign heading       = heading_reg;
    assign same_position = same_reg;
    assign distance      = dist_reg;

endmodule

// ----- hdl/odd_front.sv -----
// Front pipeline: difference, magnitudes, octant, squares and sum of squares.
module odd_front
    import odd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MB         = ((COORD_BITS + 1) < DIST_BITS) ? (COORD_BITS + 1) : DIST_BITS,
    parameter int SB         = 2 * MB + 1
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  logic signed [COORD_BITS-1:0] from_x,
    input  logic signed [COORD_BITS-1:0] from_y,
    input  logic signed [COORD_BITS-1:0] to_x,
    input  logic signed [COORD_BITS-1:0] to_y,
    output side_t                        side,
    output logic [SB-1:0]                sum
);

    localparam int DW = COORD_BITS + 1;
    localparam int CW = (DW > DIST_BITS) ? DW : DIST_BITS;

    logic                 v0_reg;
    logic signed [DW-1:0] dx_reg, dy_reg;
    side_t                side1_reg, side1_next;
    logic [MB-1:0]        axc_reg, ayc_reg, axc_next, ayc_next;
    side_t                side2_reg;
    logic [2*MB-1:0]      sqx_reg, sqy_reg;
    side_t                side3_reg;
    logic [SB-1:0]        sum_reg;

    logic [DW-1:0] ax, ay;
    logic [CW-1:0] ax_w, ay_w;
    logic          dx_zero, dy_zero, dx_neg, dy_neg, x_dom, y_dom;
    logic [HEAD_BITS-1:0] horiz, vert, diag;

    always_comb
    begin
        dx_neg  = dx_reg[DW-1];
        dy_neg  = dy_reg[DW-1];
        dx_zero = (dx_reg == '0);
        dy_zero = (dy_reg == '0);
        ax      = dx_neg ? (~dx_reg + DW'(1)) : dx_reg;
        ay      = dy_neg ? (~dy_reg + DW'(1)) : dy_reg;
        ax_w    = CW'(ax);
        ay_w    = CW'(ay);
        x_dom   = ({1'b0, ax} >= {ay, 1'b0});
        y_dom   = ({1'b0, ay} >= {ax, 1'b0});
        horiz   = dx_neg ? HEAD_W : HEAD_E;
        vert    = dy_neg ? HEAD_N : HEAD_S;
        if (dx_neg)
        begin
            diag = dy_neg ? HEAD_NW : HEAD_SW;
        end
        else
        begin
            diag = dy_neg ? HEAD_NE : HEAD_SE;
        end

        side1_next.valid = v0_reg;
        side1_next.same  = dx_zero && dy_zero;
        side1_next.sat   = (ax_w > CW'(DIST_MAX)) || (ay_w > CW'(DIST_MAX));
        if (dx_zero)
        begin
            side1_next.heading = (dy_neg || dy_zero) ? HEAD_N : HEAD_S;
        end
        else if (dy_zero)
        begin
            side1_next.heading = horiz;
        end
        else if (x_dom)
        begin
            side1_next.heading = horiz;
        end
        else if (y_dom)
        begin
            side1_next.heading = vert;
        end
        else
        begin
            side1_next.heading = diag;
        end
        // saturated magnitudes only feed a distance that is forced to the maximum
        axc_next = ax_w[MB-1:0];
        ayc_next = ay_w[MB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
        end
        else
        begin
            v0_reg    <= load;
            side1_reg <= side1_next;
            side2_reg <= side1_reg;
            side3_reg <= side2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg  <= $signed({to_x[COORD_BITS-1], to_x}) - $signed({from_x[COORD_BITS-1], from_x});
        dy_reg  <= $signed({to_y[COORD_BITS-1], to_y}) - $signed({from_y[COORD_BITS-1], from_y});
        axc_reg <= axc_next;
        ayc_reg <= ayc_next;
        sqx_reg <= axc_reg * axc_reg;
        sqy_reg <= ayc_reg * ayc_reg;
        sum_reg <= SB'(sqx_reg) + SB'(sqy_reg);
    end

    assign side = side3_reg;
    assign sum  = sum_reg;

endmodule

// ----- hdl/odd_sqrt_cell.sv -----
// One cell of the square root chain: settles one root bit per cycle.
module odd_sqrt_cell
    import odd_pkg::*;
#(
    parameter int RB = 18
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  side_t           side_in,
    input  logic [2*RB-1:0] s_in,
    input  logic [RB-1:0]   q_in,
    input  logic [RB+1:0]   r_in,
    output side_t           side_out,
    output logic [2*RB-1:0] s_out,
    output logic [RB-1:0]   q_out,
    output logic [RB+1:0]   r_out
);

    side_t           side_reg;
    logic [2*RB-1:0] s_reg, s_next;
    logic [RB-1:0]   q_reg, q_next;
    logic [RB+1:0]   r_reg, r_next;
    logic [RB+1:0]   r_sh, trial;
    logic            ge;

    always_comb
    begin
        r_sh   = {r_in[RB-1:0], s_in[2*RB-1 -: 2]};
        trial  = {q_in, 2'b01};
        ge     = (r_sh >= trial);
        r_next = ge ? (r_sh - trial) : r_sh;
        q_next = {q_in[RB-2:0], ge};
        s_next = {s_in[2*RB-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else
        begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign side_out = side_reg;
    assign s_out    = s_reg;
    assign q_out    = q_reg;
    assign r_out    = r_reg;

endmodule

// ----- hdl/odd_checker.sv -----
// Port-level checks for the octant direction and distance block, bound to the top level.
module odd_checker
    import odd_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 done,
    input logic [HEAD_BITS-1:0] heading,
    input logic                 same_position,
    input logic [DIST_BITS-1:0] distance
);

    localparam int MB  = ((COORD_BITS + 1) < DIST_BITS) ? (COORD_BITS + 1) : DIST_BITS;
    localparam int LAT = MB + 6;

    a_transfer_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("transfer without result at fixed latency");

    a_result_has_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching transfer");

    a_same_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && same_position) |-> (heading == HEAD_N && distance == '0))
        else $error("equal positions with nonzero heading or distance");

    a_apart_gives_distance: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !same_position) |-> (distance != '0))
        else $error("distinct positions with zero distance");

endmodule

bind octant_direction_and_distance odd_checker #(.COORD_BITS(COORD_BITS)) u_odd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .heading       (heading),
    .same_position (same_position),
    .distance      (distance)
);

// ----- dv/octant_direction_and_distance_tb.sv -----
// Self-checking testbench for the octant direction and distance block.
`timescale 1ns / 1ps

module octant_direction_and_distance_tb
    import odd_pkg::*;
();

    localparam int COORD_BITS = COORD_BITS_DEF;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [HEAD_BITS-1:0] heading;
        logic                 same;
        logic [DIST_BITS-1:0] distance;
    } route_t;

    class route_scoreboard;
        route_t route_q[$];
        int     errors;
        int     checked;
        int     same_cnt;
        int     head_cnt[8];

        function route_t predict(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
            longint dx;
            longint dy;
            longint ax;
            longint ay;
            longint sum_sq;
            longint root;
            longint trial;
            route_t r;
            dx = longint'(tx) - longint'(fx);
            dy = longint'(ty) - longint'(fy);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            if (dx == 0 && dy == 0)
            begin
                r.heading  = HEAD_N;
                r.same     = 1'b1;
                r.distance = '0;
                return r;
            end
            r.same = 1'b0;
            if (dx == 0)
                r.heading = dy > 0 ? HEAD_S : HEAD_N;
            else if (dy == 0)
                r.heading = dx > 0 ? HEAD_E : HEAD_W;
            else if (ax >= 2 * ay)
                r.heading = dx > 0 ? HEAD_E : HEAD_W;
            else if (ay >= 2 * ax)
                r.heading = dy > 0 ? HEAD_S : HEAD_N;
            else if (dx > 0)
                r.heading = dy > 0 ? HEAD_SE : HEAD_NE;
            else
                r.heading = dy > 0 ? HEAD_SW : HEAD_NW;
            // exact floor root, one bit at a time, then round half up
            sum_sq = ax * ax + ay * ay;
            root   = 0;
            for (int b = 20; b >= 0; b--)
            begin
                trial = root | (64'd1 << b);
                if (trial * trial <= sum_sq)
                    root = trial;
            end
            if (sum_sq > root * root + root)
                root = root + 1;
            if (root > longint'(DIST_MAX))
                root = longint'(DIST_MAX);
            r.distance = root[DIST_BITS-1:0];
            return r;
        endfunction

        function void note_pair(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
            route_q = {route_q, predict(fx, fy, tx, ty)};
        endfunction

        function void check_route(logic [HEAD_BITS-1:0] heading, logic same,
                                  logic [DIST_BITS-1:0] distance);
            route_t exp_r;
            if (route_q.size() == 0)
            begin
                $error("result with no transfer pending: heading %0d same %0b distance %0d",
                       heading, same, distance);
                errors++;
                return;
            end
            exp_r = route_q.pop_front();
            checked++;
            if (exp_r.same)
                same_cnt++;
            else
                head_cnt[exp_r.heading]++;
            if (heading !== exp_r.heading)
            begin
                $error("heading: expected %0d, got %0d", exp_r.heading, heading);
                errors++;
            end
            if (same !== exp_r.same)
            begin
                $error("same_position: expected %0b, got %0b", exp_r.same, same);
                errors++;
            end
            if (distance !== exp_r.distance)
            begin
                $error("distance: expected %0d, got %0d", exp_r.distance, distance);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    coord_t               from_x;
    coord_t               from_y;
    coord_t               to_x;
    coord_t               to_y;
    logic                 done;
    logic [HEAD_BITS-1:0] heading;
    logic                 same_position;
    logic [DIST_BITS-1:0] distance;

    route_scoreboard sb;
    int              idle_pct;
    int              phase_cnt;

    octant_direction_and_distance #(
        .COORD_BITS (COORD_BITS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .from_x        (from_x),
        .from_y        (from_y),
        .to_x          (to_x),
        .to_y          (to_y),
        .done          (done),
        .heading       (heading),
        .same_position (same_position),
        .distance      (distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_pair(from_x, from_y, to_x, to_y);
            if (done)
                sb.check_route(heading, same_position, distance);
        end
    end

    task automatic send_pair(input int fx, input int fy, input int tx, input int ty);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start  <= 1'b1;
        from_x <= coord_t'(fx);
        from_y <= coord_t'(fy);
        to_x   <= coord_t'(tx);
        to_y   <= coord_t'(ty);
        do @(posedge clk); while (busy);
    endtask

    task automatic send_random_pair();
        int edge_vals[7];
        int fx;
        int fy;
        int dx;
        int dy;
        int tmp;
        edge_vals = '{-32768, -32767, -1, 0, 1, 32766, 32767};
        fx = $urandom_range(0, 65535) - 32768;
        fy = $urandom_range(0, 65535) - 32768;
        case ($urandom_range(0, 9))
            0, 1, 2:
            begin
                dx = $urandom_range(0, 65535) - 32768 - fx;
                dy = $urandom_range(0, 65535) - 32768 - fy;
            end
            3, 4:
            begin
                dx = $urandom_range(0, 16) - 8;
                dy = $urandom_range(0, 16) - 8;
            end
            5:
            begin
                dx = $urandom_range(0, 65535) - 32768 - fx;
                dy = $urandom_range(0, 65535) - 32768 - fy;
                if ($urandom_range(0, 1)) dx = 0;
                else dy = 0;
            end
            6:
            begin
                dx = 0;
                dy = 0;
            end
            7:
            begin
                // straddle the two-to-one ratio between axis and diagonal
                fx = $urandom_range(0, 32767) - 16384;
                fy = $urandom_range(0, 32767) - 16384;
                dy = $urandom_range(1, 8000);
                dx = 2 * dy + $urandom_range(0, 2) - 1;
                if ($urandom_range(0, 1))
                begin
                    tmp = dx;
                    dx  = dy;
                    dy  = tmp;
                end
                if ($urandom_range(0, 1)) dx = -dx;
                if ($urandom_range(0, 1)) dy = -dy;
            end
            8:
            begin
                fx = edge_vals[$urandom_range(0, 6)];
                fy = edge_vals[$urandom_range(0, 6)];
                dx = edge_vals[$urandom_range(0, 6)] - fx;
                dy = edge_vals[$urandom_range(0, 6)] - fy;
            end
            default:
            begin
                dx = $urandom_range(0, 600) - 300;
                dy = $urandom_range(0, 600) - 300;
            end
        endcase
        send_pair(fx, fy, fx + dx, fy + dy);
    endtask

    initial
    begin
        int idle_set[6];
        sb       = new();
        idle_set = '{0, 70, 35, 0, 70, 35};
        idle_pct = 0;
        rst_n    = 1'b0;
        start    = 1'b0;
        from_x   = '0;
        from_y   = '0;
        to_x     = '0;
        to_y     = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // equal positions, pure axes, diagonals, ratio edges, widest differences
        send_pair(0, 0, 0, 0);
        send_pair(-32768, 32767, -32768, 32767);
        send_pair(0, 0, 0, -5);
        send_pair(0, 0, 0, 5);
        send_pair(0, 0, 5, 0);
        send_pair(0, 0, -5, 0);
        send_pair(0, 0, 1, -1);
        send_pair(0, 0, 1, 1);
        send_pair(0, 0, -1, 1);
        send_pair(0, 0, -1, -1);
        send_pair(10, 10, 12, 11);
        send_pair(10, 10, 13, 8);
        send_pair(-7, 3, -8, 5);
        send_pair(100, -100, 99, -102);
        send_pair(-32768, -32768, 32767, 32767);
        send_pair(32767, 32767, -32768, -32768);
        send_pair(32767, -32768, -32768, 32767);
        send_pair(-32768, 32767, 32767, -32768);
        send_pair(32767, 0, -32768, 0);
        send_pair(0, -32768, 0, 32767);
        send_pair(-1, -1, 0, 0);
        send_pair(0, 0, 65535 / 2, 1);

        phase_cnt = 0;
        foreach (idle_set[p])
        begin
            idle_pct = idle_set[p];
            phase_cnt++;
            repeat (305) send_random_pair();
        end
        @(negedge clk);
        start <= 1'b0;

        while (sb.route_q.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Checked %0d transfers (%0d equal positions) over %0d idle phases.",
                 sb.checked, sb.same_cnt, phase_cnt);
        $display("Results per heading N..NW: %0d %0d %0d %0d %0d %0d %0d %0d",
                 sb.head_cnt[0], sb.head_cnt[1], sb.head_cnt[2], sb.head_cnt[3],
                 sb.head_cnt[4], sb.head_cnt[5], sb.head_cnt[6], sb.head_cnt[7]);
        if (sb.errors == 0 && sb.route_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/odd_pkg.sv
hdl/odd_front.sv
hdl/odd_sqrt_cell.sv
hdl/octant_direction_and_distance.sv
hdl/odd_checker.sv
dv/octant_direction_and_distance_tb.sv
